// File: hw/rtl/sbda_pkg.sv
`timescale 1ns / 1ps

package sbda_pkg;

    typedef logic [6:0] char_t;

    localparam int DEFAULT_VALUE_BITS = 64;

    localparam char_t CHAR_ZERO  = 7'h30;
    localparam char_t CHAR_MINUS = 7'h2D;

    // digits of 2^(bits-1), the largest magnitude; 1233/4096 approximates log10(2)
    function automatic int digit_count(input int bits);
        int n;
        n = (((bits - 1) * 1233) >> 12) + 1;
        return n;
    endfunction

endpackage

// File: hw/rtl/sbda_front.sv
`timescale 1ns / 1ps

module sbda_front
    import sbda_pkg::*;
#(
    parameter int VALUE_BITS = DEFAULT_VALUE_BITS
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [63:0]           value,
    input  logic                  in_valid,
    output logic                  in_ready,
    output logic [VALUE_BITS:0]   push_entry,
    output logic                  push_valid,
    input  logic                  push_ready
);

    logic                  valid_reg;
    logic                  valid_next;
    logic [VALUE_BITS:0]   entry_reg;
    logic [VALUE_BITS-1:0] raw;
    logic                  negative;
    logic [VALUE_BITS-1:0] magnitude;

    // drop the bits above the width, take the magnitude unsigned
    assign raw       = value[VALUE_BITS-1:0];
    assign negative  = raw[VALUE_BITS-1];
    assign magnitude = negative ? (~raw + {{(VALUE_BITS-1){1'b0}}, 1'b1}) : raw;

    assign in_ready   = !valid_reg || push_ready;
    assign push_valid = valid_reg;
    assign push_entry = entry_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (push_ready)
        begin
            valid_next = 1'b0;
        end
        if (in_valid && in_ready)
        begin
            valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            entry_reg <= {negative, magnitude};
        end
    end

endmodule

// File: hw/rtl/sbda_queue.sv
`timescale 1ns / 1ps

module sbda_queue
    import sbda_pkg::*;
#(
    parameter int VALUE_BITS = DEFAULT_VALUE_BITS
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [VALUE_BITS:0]   push_entry,
    input  logic                  push_valid,
    output logic                  push_ready,
    output logic [VALUE_BITS:0]   pop_entry,
    output logic                  pop_valid,
    input  logic                  pop_ready
);

    logic [VALUE_BITS:0] mem [2];
    logic                wr_ptr_reg;
    logic                rd_ptr_reg;
    logic [1:0]          count_reg;
    logic                push;
    logic                pop;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_entry  = mem[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

// File: hw/rtl/sbda_back.sv
`timescale 1ns / 1ps

module sbda_back
    import sbda_pkg::*;
#(
    parameter int VALUE_BITS = DEFAULT_VALUE_BITS
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [VALUE_BITS:0]   pop_entry,
    input  logic                  pop_valid,
    output logic                  pop_ready,
    output char_t                 character,
    output logic                  last,
    output logic                  out_valid,
    input  logic                  out_ready
);

    localparam int NDIG     = digit_count(VALUE_BITS);
    localparam int BCD_BITS = 4 * NDIG;
    localparam int BIT_W    = $clog2(VALUE_BITS);
    localparam int DIG_W    = $clog2(NDIG);
    localparam logic [BIT_W-1:0] LAST_BIT = BIT_W'(VALUE_BITS - 1);
    localparam logic [DIG_W-1:0] LAST_DIG = DIG_W'(NDIG - 1);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_CONV = 3'd1;
    localparam logic [2:0] ST_SKIP = 3'd2;
    localparam logic [2:0] ST_SIGN = 3'd3;
    localparam logic [2:0] ST_EMIT = 3'd4;

    logic [2:0]            state_reg;
    logic [2:0]            state_next;
    logic [VALUE_BITS-1:0] bin_reg;
    logic [VALUE_BITS-1:0] bin_next;
    logic [BCD_BITS-1:0]   bcd_reg;
    logic [BCD_BITS-1:0]   bcd_next;
    logic                  neg_reg;
    logic                  neg_next;
    logic [BIT_W-1:0]      bit_cnt_reg;
    logic [BIT_W-1:0]      bit_cnt_next;
    logic [DIG_W-1:0]      dig_cnt_reg;
    logic [DIG_W-1:0]      dig_cnt_next;
    char_t                 char_reg;
    char_t                 char_next;
    logic                  last_reg;
    logic                  last_next;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic                  load_out;

    logic [BCD_BITS-1:0]   bcd_adj;
    logic [BCD_BITS-1:0]   bcd_shift;
    logic [3:0]            top_digit;
    logic                  slot_free;

    assign top_digit = bcd_reg[BCD_BITS-1 -: 4];
    assign slot_free = !out_valid_reg || out_ready;
    assign pop_ready = (state_reg == ST_IDLE);
    assign character = char_reg;
    assign last      = last_reg;
    assign out_valid = out_valid_reg;

    // add 3 to every digit of five or more before the shift
    always_comb
    begin
        for (int d = 0; d < NDIG; d++)
        begin
            if (bcd_reg[4*d +: 4] >= 4'd5)
            begin
                bcd_adj[4*d +: 4] = bcd_reg[4*d +: 4] + 4'd3;
            end
            else
            begin
                bcd_adj[4*d +: 4] = bcd_reg[4*d +: 4];
            end
        end
        bcd_shift = {bcd_adj[BCD_BITS-2:0], bin_reg[VALUE_BITS-1]};
    end

    always_comb
    begin
        state_next     = state_reg;
        bin_next       = bin_reg;
        bcd_next       = bcd_reg;
        neg_next       = neg_reg;
        bit_cnt_next   = bit_cnt_reg;
        dig_cnt_next   = dig_cnt_reg;
        char_next      = char_reg;
        last_next      = last_reg;
        out_valid_next = out_valid_reg;
        load_out       = 1'b0;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (pop_valid)
                begin
                    bin_next     = pop_entry[VALUE_BITS-1:0];
                    neg_next     = pop_entry[VALUE_BITS];
                    bcd_next     = '0;
                    bit_cnt_next = '0;
                    dig_cnt_next = '0;
                    state_next   = ST_CONV;
                end
            end
            ST_CONV:
            begin
                bcd_next     = bcd_shift;
                bin_next     = {bin_reg[VALUE_BITS-2:0], 1'b0};
                bit_cnt_next = bit_cnt_reg + BIT_W'(1);
                if (bit_cnt_reg == LAST_BIT)
                begin
                    state_next = ST_SKIP;
                end
            end
            ST_SKIP:
            begin
                // drop leading zeros, keep at least one digit
                if (top_digit == 4'd0 && dig_cnt_reg != LAST_DIG)
                begin
                    bcd_next     = {bcd_reg[BCD_BITS-5:0], 4'd0};
                    dig_cnt_next = dig_cnt_reg + DIG_W'(1);
                end
                else
                begin
                    state_next = neg_reg ? ST_SIGN : ST_EMIT;
                end
            end
            ST_SIGN:
            begin
                if (slot_free)
                begin
                    char_next      = CHAR_MINUS;
                    last_next      = 1'b0;
                    out_valid_next = 1'b1;
                    load_out       = 1'b1;
                    state_next     = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (slot_free)
                begin
                    char_next      = CHAR_ZERO + char_t'(top_digit);
                    last_next      = (dig_cnt_reg == LAST_DIG);
                    out_valid_next = 1'b1;
                    load_out       = 1'b1;
                    bcd_next       = {bcd_reg[BCD_BITS-5:0], 4'd0};
                    dig_cnt_next   = dig_cnt_reg + DIG_W'(1);
                    if (dig_cnt_reg == LAST_DIG)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            bit_cnt_reg   <= '0;
            dig_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            bit_cnt_reg   <= bit_cnt_next;
            dig_cnt_reg   <= dig_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bin_reg <= bin_next;
        bcd_reg <= bcd_next;
        neg_reg <= neg_next;
        if (load_out)
        begin
            char_reg <= char_next;
            last_reg <= last_next;
        end
    end

endmodule

// File: hw/rtl/signed_binary_to_decimal_ascii.sv
// A request passes the front register and the queue to the back end, which converts it
// with a one-bit-per-cycle double-dabble pass, skips leading zeros and then emits
//   one character per cycle while out_ready allows, a minus sign first if negative.
// A two-entry queue lets requests be taken while the back end converts and emits.
// Reset (rst_n, async, active low) empties the queue and idles both ends.
`timescale 1ns / 1ps

module signed_binary_to_decimal_ascii
    import sbda_pkg::*;
#(
    parameter int VALUE_BITS = DEFAULT_VALUE_BITS
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic [63:0] value,
    input  logic        in_valid,
    output logic        in_ready,
    output char_t       character,
    output logic        last,
    output logic        out_valid,
    input  logic        out_ready
);

    logic [VALUE_BITS:0] push_entry;
    logic                push_valid;
    logic                push_ready;
    logic [VALUE_BITS:0] pop_entry;
    logic                pop_valid;
    logic                pop_ready;

    sbda_front #(
        .VALUE_BITS (VALUE_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .value      (value),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .push_entry (push_entry),
        .push_valid (push_valid),
        .push_ready (push_ready)
    );

    sbda_queue #(
        .VALUE_BITS (VALUE_BITS)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_entry (push_entry),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .pop_entry  (pop_entry),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready)
    );

    sbda_back #(
        .VALUE_BITS (VALUE_BITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .pop_entry  (pop_entry),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .character  (character),
        .last       (last),
        .out_valid  (out_valid),
        .out_ready  (out_ready)
    );

endmodule
